// ----- hdl/packet_serial_link_crc16_core_macros.svh -----
// ---------------------------------------------------------------------------
// Packet serial link CRC16 core - assertion macros
// Clocked assertion wrappers, empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef PACKET_SERIAL_LINK_CRC16_CORE_MACROS_SVH
`define PACKET_SERIAL_LINK_CRC16_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define PSLC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define PSLC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define PSLC_ASSERT(lbl, prop, msg)

`define PSLC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- hdl/pslc_pkg.sv -----
// ---------------------------------------------------------------------------
// Packet serial link CRC16 package
// Shared types, codes and the byte-wide CRC-16 update.
// ---------------------------------------------------------------------------
package pslc_pkg;

   localparam logic [7:0]  MAX_PAYLOAD   = 8'd32;
   localparam logic [15:0] TIMEOUT_RESET = 16'd50;
   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [7:0]  ACK_BYTE      = 8'hFF;
   localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

   typedef enum logic [2:0] {
      ACT_WRITE   = 3'd0,
      ACT_READ    = 3'd1,
      ACT_PAYLOAD = 3'd2,
      ACT_RECV    = 3'd3,
      ACT_TICK    = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      KIND_TX     = 2'd0,
      KIND_RX     = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_TIMEOUT = 3'd1,
      ST_CRC     = 3'd2,
      ST_BAD_ACK = 3'd3,
      ST_REJECT  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_PAYLOAD = 3'd1,
      PH_ACK     = 3'd2,
      PH_DATA    = 3'd3,
      PH_CRCHI   = 3'd4,
      PH_CRCLO   = 3'd5
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_out;
      logic [2:0] status;
   } rsp_type;

   // results of one request, handed from engine to response buffer
   typedef struct packed {
      logic             valid;
      logic [2:0]       count;
      rsp_type [3:0]    rsp;
   } bundle_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic rsp_type mk_rsp(input kind_type k, input logic [7:0] b,
                                      input status_type s);
      rsp_type r;
      r.kind     = k;
      r.byte_out = b;
      r.status   = s;
      return r;
   endfunction

endpackage

// ----- hdl/pslc_engine.sv -----
// ---------------------------------------------------------------------------
// Packet serial link engine
// Request register, link state and the single-pass step logic.
// ---------------------------------------------------------------------------
module pslc_engine import pslc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [2:0]       req_action,
   input  logic [7:0]       req_address,
   input  logic [7:0]       req_command,
   input  logic [5:0]       req_length,
   input  logic [7:0]       req_byte_in,
   input  logic [15:0]      timeout_ticks,
   input  logic             bundle_ready,
   output bundle_type       bundle
);

   logic         in_valid_ff;
   logic [2:0]   act_ff;
   logic [7:0]   addr_ff;
   logic [7:0]   cmd_ff;
   logic [5:0]   len_ff;
   logic [7:0]   byte_ff;

   phase_type    phase_ff, phase_in;
   logic [15:0]  crc_ff, crc_in;
   logic [5:0]   done_ff, done_in;
   logic [5:0]   exp_ff, exp_in;
   logic [7:0]   hi_ff, hi_in;
   logic [15:0]  wait_ff, wait_in;

   logic         in_take;
   logic         start_ok;
   logic         waiting;
   logic [15:0]  crc_start;
   logic [15:0]  crc_byte;
   logic [5:0]   done_inc;
   logic         done_reach;
   logic [15:0]  wait_inc;
   logic         timed_out;
   bundle_type   bnd;

   assign start_ok   = (phase_ff == PH_IDLE) && ({2'b00, len_ff} <= MAX_PAYLOAD);
   assign waiting    = phase_ff inside {PH_ACK, PH_DATA, PH_CRCHI, PH_CRCLO};
   assign crc_start  = crc_feed(crc_feed(16'h0000, addr_ff), cmd_ff);
   assign crc_byte   = crc_feed(crc_ff, byte_ff);
   assign done_inc   = done_ff + 6'd1;
   assign done_reach = done_inc >= exp_ff;
   assign wait_inc   = (wait_ff == TICKS_MAX) ? wait_ff : wait_ff + 16'd1;
   assign timed_out  = wait_inc > timeout_ticks;

   assign in_take    = in_valid_ff && ((bnd.count == 3'd0) || bundle_ready);
   assign req_tready = !in_valid_ff || in_take;

   // next state
   always_comb begin
      phase_in = phase_ff;
      crc_in   = crc_ff;
      done_in  = done_ff;
      exp_in   = exp_ff;
      hi_in    = hi_ff;
      wait_in  = wait_ff;
      case (act_ff)
         ACT_WRITE, ACT_READ: begin
            if (start_ok) begin
               crc_in  = crc_start;
               done_in = 6'd0;
               exp_in  = len_ff;
               hi_in   = 8'h00;
               wait_in = 16'd0;
               if (act_ff == ACT_WRITE) begin
                  phase_in = (len_ff == 6'd0) ? PH_ACK : PH_PAYLOAD;
               end else begin
                  phase_in = (len_ff == 6'd0) ? PH_CRCHI : PH_DATA;
               end
            end
         end
         ACT_PAYLOAD: begin
            if (phase_ff == PH_PAYLOAD) begin
               crc_in  = crc_byte;
               done_in = done_inc;
               if (done_reach) begin
                  wait_in  = 16'd0;
                  phase_in = PH_ACK;
               end
            end
         end
         ACT_RECV: begin
            case (phase_ff)
               PH_ACK: phase_in = PH_IDLE;
               PH_DATA: begin
                  crc_in  = crc_byte;
                  done_in = done_inc;
                  if (done_reach) begin
                     phase_in = PH_CRCHI;
                  end
               end
               PH_CRCHI: begin
                  hi_in    = byte_ff;
                  phase_in = PH_CRCLO;
               end
               PH_CRCLO: phase_in = PH_IDLE;
               default: ;
            endcase
         end
         ACT_TICK: begin
            if (waiting) begin
               wait_in = wait_inc;
               if (timed_out) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         default: ;
      endcase
   end

   // results
   always_comb begin
      bnd = '0;
      case (act_ff)
         ACT_WRITE, ACT_READ: begin
            if (start_ok) begin
               bnd.rsp[0] = mk_rsp(KIND_TX, addr_ff, ST_OK);
               bnd.rsp[1] = mk_rsp(KIND_TX, cmd_ff, ST_OK);
               bnd.count  = 3'd2;
               if (act_ff == ACT_WRITE && len_ff == 6'd0) begin
                  bnd.rsp[2] = mk_rsp(KIND_TX, crc_start[15:8], ST_OK);
                  bnd.rsp[3] = mk_rsp(KIND_TX, crc_start[7:0], ST_OK);
                  bnd.count  = 3'd4;
               end
            end else begin
               bnd.rsp[0] = mk_rsp(KIND_STATUS, 8'h00, ST_REJECT);
               bnd.count  = 3'd1;
            end
         end
         ACT_PAYLOAD: begin
            if (phase_ff == PH_PAYLOAD) begin
               bnd.rsp[0] = mk_rsp(KIND_TX, byte_ff, ST_OK);
               bnd.count  = 3'd1;
               if (done_reach) begin
                  bnd.rsp[1] = mk_rsp(KIND_TX, crc_byte[15:8], ST_OK);
                  bnd.rsp[2] = mk_rsp(KIND_TX, crc_byte[7:0], ST_OK);
                  bnd.count  = 3'd3;
               end
            end else begin
               bnd.rsp[0] = mk_rsp(KIND_STATUS, 8'h00, ST_REJECT);
               bnd.count  = 3'd1;
            end
         end
         ACT_RECV: begin
            case (phase_ff)
               PH_ACK: begin
                  bnd.rsp[0] = mk_rsp(KIND_STATUS, 8'h00,
                                      (byte_ff == ACK_BYTE) ? ST_OK : ST_BAD_ACK);
                  bnd.count  = 3'd1;
               end
               PH_DATA: begin
                  bnd.rsp[0] = mk_rsp(KIND_RX, byte_ff, ST_OK);
                  bnd.count  = 3'd1;
               end
               PH_CRCHI: bnd.count = 3'd0;
               PH_CRCLO: begin
                  bnd.rsp[0] = mk_rsp(KIND_STATUS, 8'h00,
                                      ({hi_ff, byte_ff} == crc_ff) ? ST_OK : ST_CRC);
                  bnd.count  = 3'd1;
               end
               default: begin
                  bnd.rsp[0] = mk_rsp(KIND_STATUS, 8'h00, ST_REJECT);
                  bnd.count  = 3'd1;
               end
            endcase
         end
         ACT_TICK: begin
            if (waiting && timed_out) begin
               bnd.rsp[0] = mk_rsp(KIND_STATUS, 8'h00, ST_TIMEOUT);
               bnd.count  = 3'd1;
            end
         end
         default: begin
            bnd.rsp[0] = mk_rsp(KIND_STATUS, 8'h00, ST_REJECT);
            bnd.count  = 3'd1;
         end
      endcase
      bnd.valid = in_valid_ff && (bnd.count != 3'd0);
   end

   assign bundle = bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         act_ff  <= req_action;
         addr_ff <= req_address;
         cmd_ff  <= req_command;
         len_ff  <= req_length;
         byte_ff <= req_byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         crc_ff   <= 16'h0000;
         done_ff  <= 6'd0;
         exp_ff   <= 6'd0;
         hi_ff    <= 8'h00;
         wait_ff  <= 16'd0;
      end else if (in_take) begin
         phase_ff <= phase_in;
         crc_ff   <= crc_in;
         done_ff  <= done_in;
         exp_ff   <= exp_in;
         hi_ff    <= hi_in;
         wait_ff  <= wait_in;
      end
   end

`include "packet_serial_link_crc16_core_macros.svh"

   `PSLC_ASSERT(a_phase_hold, !in_take |=> $stable(phase_ff), "phase moved without a request")
   `PSLC_ASSERT(a_payload_left, (phase_ff == PH_PAYLOAD) |-> (done_ff < exp_ff), "payload count overrun")
   `PSLC_ASSERT(a_data_left, (phase_ff == PH_DATA) |-> (done_ff < exp_ff), "data count overrun")

endmodule

// ----- hdl/pslc_rsp_buf.sv -----
// ---------------------------------------------------------------------------
// Packet serial link response buffer
// Holds the results of one request and streams them out one per cycle while rsp_tready is high.
// ---------------------------------------------------------------------------
module pslc_rsp_buf import pslc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  bundle_type  bundle,
   output logic        bundle_ready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output rsp_type     rsp_item,
   output logic        rsp_last
);

   logic [2:0]      cnt_ff;
   logic [1:0]      idx_ff;
   rsp_type [3:0]   rsp_ff;
   logic            fire;
   logic            drain_last;
   logic            load;

   assign rsp_tvalid   = cnt_ff != 3'd0;
   assign rsp_item     = rsp_ff[idx_ff];
   assign rsp_last     = {1'b0, idx_ff} == (cnt_ff - 3'd1);
   assign fire         = rsp_tvalid && rsp_tready;
   assign drain_last   = fire && rsp_last;
   assign bundle_ready = (cnt_ff == 3'd0) || drain_last;
   assign load         = bundle.valid && bundle_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else if (load) begin
         cnt_ff <= bundle.count;
         idx_ff <= 2'd0;
      end else if (drain_last) begin
         cnt_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else if (fire) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= bundle.rsp;
      end
   end

`include "packet_serial_link_crc16_core_macros.svh"

   `PSLC_ASSERT(a_idx_range, rsp_tvalid |-> ({1'b0, idx_ff} < cnt_ff), "response index past count")
   `PSLC_ASSERT(a_cnt_range, cnt_ff <= 3'd4, "response count too large")

endmodule

// ----- hdl/packet_serial_link_crc16_core.sv -----
// A request is held in the input register; the step logic then updates the link
// state and hands its results (none to four) to the response buffer, which emits one per
// cycle while rsp_tready is high. A request with results is taken only when the buffer
// has room; ticks, CRC bytes and single-result requests flow at one per cycle unless the
// consumer stalls, and a start with an empty write yields four results.
// ---------------------------------------------------------------------------
// Packet serial link CRC16 core
// Master side of a packet serial link: frames commands with CRC-16 and checks replies.
// ---------------------------------------------------------------------------
module packet_serial_link_crc16_core import pslc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // address, command, length, byte_in, zero pad
   input  logic [2:0]   req_tuser,   // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // byte_out, status, zero pad
   output logic [1:0]   rsp_tuser,   // kind
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);

   logic [15:0]  timeout_ff;
   bundle_type   bundle;
   logic         bundle_ready;
   rsp_type      rsp_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   pslc_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_action    (req_tuser),
      .req_address   (req_tdata[7:0]),
      .req_command   (req_tdata[15:8]),
      .req_length    (req_tdata[21:16]),
      .req_byte_in   (req_tdata[29:22]),
      .timeout_ticks (timeout_ff),
      .bundle_ready  (bundle_ready),
      .bundle        (bundle)
   );

   pslc_rsp_buf u_rsp_buf (
      .clock        (clock),
      .reset        (reset),
      .bundle       (bundle),
      .bundle_ready (bundle_ready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_item     (rsp_item),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {5'b00000, rsp_item.status, rsp_item.byte_out};
   assign rsp_tuser = rsp_item.kind;

endmodule
